// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Define SYNTH to drop every check from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on each rising edge, masked while reset is active.
`define PTW_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on each rising edge, including during reset.
`define PTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PTW_ASSERT(lbl, clk, rstn, prop, msg)
`define PTW_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/sv39ptw_pkg.sv =====
package sv39ptw_pkg;

	// Field widths
	localparam int VA_W     = 39;
	localparam int PA_W     = 56;
	localparam int PERM_W   = 8;
	localparam int PTE_W    = 54;
	localparam int PPN_W    = 44;
	localparam int FLAG_W   = 10;
	localparam int STATUS_W = 3;
	localparam int VPN_W    = 9;
	localparam int OFF_W    = 12;

	// Table geometry
	localparam int ENTRIES_PER_PAGE = 512;

	// PTE flag positions
	localparam int PTE_V     = 0;
	localparam int PTE_R     = 1;
	localparam int PTE_X     = 3;

	// Commands
	localparam logic CMD_MAP    = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_UNALIGNED = 3'd1,
		STAT_NO_PAGES  = 3'd2,
		STAT_MAPPED    = 3'd3,
		STAT_MISSING   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		LVL_LEAF = 2'd0,
		LVL_MID  = 2'd1,
		LVL_ROOT = 2'd2
	} level_t;

	// Pick the VPN slice that indexes the table at one level
	function automatic logic [VPN_W-1:0] vpn_slice(logic [VA_W-1:0] va, level_t lvl);
		logic [VPN_W-1:0] s;
		unique case (lvl)
			LVL_ROOT: s = va[OFF_W+2*VPN_W +: VPN_W];
			LVL_MID:  s = va[OFF_W+VPN_W +: VPN_W];
			default:  s = va[OFF_W +: VPN_W];
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/sv39ptw_req_if.sv =====
interface sv39ptw_req_if;
	logic                            valid;
	logic                            ready;
	logic                            cmd;
	logic [sv39ptw_pkg::VA_W-1:0]    virt_addr;
	logic [sv39ptw_pkg::PA_W-1:0]    phys_addr;
	logic [sv39ptw_pkg::PERM_W-1:0]  perm_bits;

	modport source (output valid, cmd, virt_addr, phys_addr, perm_bits, input ready);
	modport sink   (input valid, cmd, virt_addr, phys_addr, perm_bits, output ready);
endinterface

// ===== hdl/sv39ptw_rsp_if.sv =====
interface sv39ptw_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [sv39ptw_pkg::STATUS_W-1:0]  status;
	logic [sv39ptw_pkg::PTE_W-1:0]     leaf_entry;

	modport source (output valid, status, leaf_entry, input ready);
	modport sink   (input valid, status, leaf_entry, output ready);
endinterface

// ===== hdl/sv39ptw_ram.sv =====
module sv39ptw_ram #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13,
	parameter int DATA_W = 55
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read word
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/sv39ptw_alu.sv =====
module sv39ptw_alu #(
	parameter int POOL_PAGES = 16
) (
	input  logic                         sub,
	input  logic [sv39ptw_pkg::PPN_W-1:0] a,
	input  logic [sv39ptw_pkg::PPN_W-1:0] b,
	output logic [sv39ptw_pkg::PPN_W-1:0] sum,
	output logic                         in_pool
);
	import sv39ptw_pkg::*;

	logic [PPN_W-1:0] b_op;

	// Add or subtract modulo 2^44, then range-check against the pool
	always_comb begin
		b_op    = sub ? ~b : b;
		sum     = a + b_op + PPN_W'(sub);
		in_pool = (sum < PPN_W'(POOL_PAGES));
	end

endmodule

// ===== hdl/sv39_page_table_walk_map_unit.sv =====
// Channel | Dir | Handshake      | Payload
// --------+-----+----------------+---------------------------------------------
// req     | in  | valid / ready  | cmd, virt_addr, phys_addr, perm_bits
// rsp     | out | valid / ready  | status, leaf_entry
// cfg     | in  | cfg_we         | cfg_wdata (table_base_ppn)
//
// A request is accepted in S_IDLE. Each table level then takes an S_READ (one read
// of the table memory) and an S_EVAL state, and S_DONE presents the result; an
// unaligned map goes from S_IDLE straight to S_DONE.
// After reset a clearing pass writes every table entry, POOL_PAGES * 512
// entries (8192 at the default); no request is taken until it ends.
// One request is in flight at a time; req.ready is low until rsp is taken.
`include "assert_macros.svh"

module sv39_page_table_walk_map_unit #(
	parameter int POOL_PAGES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sv39ptw_pkg::PPN_W-1:0] cfg_wdata,
	sv39ptw_req_if.sink                  req,
	sv39ptw_rsp_if.source                rsp
);
	import sv39ptw_pkg::*;

	localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int NF_W   = $clog2(POOL_PAGES + 1);
	localparam int ADDR_W = PAGE_W + VPN_W;
	localparam int DEPTH  = POOL_PAGES * ENTRIES_PER_PAGE;
	localparam int MEM_W  = PTE_W + 1;

	// Control state
	state_t            state_q, state_d;
	level_t            lvl_q;
	logic [PAGE_W-1:0] page_q, page_d;
	logic [NF_W-1:0]   nf_q;
	logic [PPN_W-1:0]  base_q;
	logic [ADDR_W-1:0] clr_q;

	// Request and result words
	logic              cmd_q;
	logic [VA_W-1:0]   va_q;
	logic [PA_W-1:0]   pa_q;
	logic [PERM_W-1:0] perm_q;
	status_t           status_q, res_status;
	logic [PTE_W-1:0]  leaf_q, res_leaf;

	// Sequencer controls
	logic              req_take, res_load, descend, alloc;

	// Table memory
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, cur_addr;
	logic [MEM_W-1:0]  mem_wdata, mem_rdata;

	// Entry evaluation
	logic              page_live, tag_alloc;
	logic [PTE_W-1:0]  entry;
	logic              alu_sub, alu_in_pool;
	logic [PPN_W-1:0]  alu_a, alu_sum;
	logic              bad_ptr, unaligned;

	sv39ptw_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (MEM_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (cur_addr),
		.rdata (mem_rdata)
	);

	sv39ptw_alu #(
		.POOL_PAGES (POOL_PAGES)
	) u_alu (
		.sub     (alu_sub),
		.a       (alu_a),
		.b       (base_q),
		.sum     (alu_sum),
		.in_pool (alu_in_pool)
	);

	// Form the table index for the current level
	assign cur_addr = {page_q, vpn_slice(va_q, lvl_q)};

	// Mask entries written to a page before it was allocated: allocation clears them.
	// The tag bit records whether the page was allocated when the entry was written.
	always_comb begin
		page_live = (NF_W'(page_q) < nf_q);
		tag_alloc = ((NF_W+1)'(page_q) <= (NF_W+1)'(nf_q));
		entry     = (page_live && !mem_rdata[PTE_W]) ? '0 : mem_rdata[PTE_W-1:0];
		alu_sub   = entry[PTE_V];
		alu_a     = entry[PTE_V] ? entry[FLAG_W +: PPN_W] : PPN_W'(nf_q);
		bad_ptr   = (entry[PTE_X:PTE_R] != '0) || !alu_in_pool;
		unaligned = (req.virt_addr[OFF_W-1:0] != '0) || (req.phys_addr[OFF_W-1:0] != '0);
	end

	// Sequence the walk
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = cur_addr;
		mem_wdata  = '0;
		req_take   = 1'b0;
		res_load   = 1'b0;
		res_status = STAT_OK;
		res_leaf   = '0;
		descend    = 1'b0;
		alloc      = 1'b0;
		page_d     = page_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					req_take = 1'b1;
					if (req.cmd == CMD_MAP && unaligned) begin
						res_load   = 1'b1;
						res_status = STAT_UNALIGNED;
						state_d    = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (lvl_q != LVL_LEAF) begin
					if (entry[PTE_V]) begin
						if (bad_ptr) begin
							res_load   = 1'b1;
							res_status = STAT_MISSING;
							state_d    = S_DONE;
						end else begin
							page_d  = alu_sum[PAGE_W-1:0];
							descend = 1'b1;
							state_d = S_READ;
						end
					end else if (cmd_q == CMD_LOOKUP) begin
						res_load   = 1'b1;
						res_status = STAT_MISSING;
						state_d    = S_DONE;
					end else if (nf_q >= NF_W'(POOL_PAGES)) begin
						res_load   = 1'b1;
						res_status = STAT_NO_PAGES;
						state_d    = S_DONE;
					end else begin
						// Link a fresh page
						mem_we    = 1'b1;
						mem_wdata = {tag_alloc, alu_sum, {(FLAG_W-1){1'b0}}, 1'b1};
						alloc     = 1'b1;
						page_d    = nf_q[PAGE_W-1:0];
						descend   = 1'b1;
						state_d   = S_READ;
					end
				end else begin
					res_load = 1'b1;
					state_d  = S_DONE;
					if (cmd_q == CMD_MAP) begin
						if (entry[PTE_V]) begin
							res_status = STAT_MAPPED;
						end else begin
							res_leaf  = {pa_q[OFF_W +: PPN_W], 2'b00, perm_q | PERM_W'(1)};
							mem_we    = 1'b1;
							mem_wdata = {page_live, res_leaf};
						end
					end else if (entry[PTE_V]) begin
						res_leaf = entry;
					end else begin
						res_status = STAT_MISSING;
					end
				end
			end
			S_DONE: begin
				if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = (state_q == S_DONE);
	assign rsp.status     = status_q;
	assign rsp.leaf_entry = leaf_q;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			nf_q    <= NF_W'(1);
			base_q  <= '0;
			lvl_q   <= LVL_ROOT;
			page_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (alloc) begin
				nf_q <= nf_q + NF_W'(1);
			end
			if (req_take) begin
				lvl_q  <= LVL_ROOT;
				page_q <= '0;
			end else if (descend) begin
				lvl_q  <= (lvl_q == LVL_ROOT) ? LVL_MID : LVL_LEAF;
				page_q <= page_d;
			end
		end
	end

	// Capture the request and result words
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q  <= req.cmd;
			va_q   <= req.virt_addr;
			pa_q   <= req.phys_addr;
			perm_q <= req.perm_bits;
		end
		if (res_load) begin
			status_q <= res_status;
			leaf_q   <= res_leaf;
		end
	end

	`PTW_ASSERT(a_busy_no_ready, clk, arst_n, req.ready |-> !rsp.valid, "ready while result pending")
	`PTW_ASSERT(a_alloc_step, clk, arst_n, nf_q != $past(nf_q) |-> nf_q == $past(nf_q) + NF_W'(1), "allocator moved by more than one page")
	`PTW_ASSERT(a_alloc_bound, clk, arst_n, nf_q >= NF_W'(1) && nf_q <= NF_W'(POOL_PAGES), "allocator out of range")
	`PTW_ASSERT(a_write_when, clk, arst_n, mem_we |-> (state_q == S_CLEAR || state_q == S_EVAL), "table write outside clear or evaluate")
	`PTW_ASSERT(a_fail_zero, clk, arst_n, rsp.valid && rsp.status != STAT_OK |-> rsp.leaf_entry == '0, "nonzero leaf on failure")

endmodule
